// ----- src/rc4sc_pkg.sv -----
`timescale 1ns / 1ps

package rc4sc_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int PERM_SIZE     = 256;
  localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_CW        = $clog2(MAX_KEY_BYTES + 1);

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic       wr;
    logic       last;
    logic [7:0] data;
    logic       idx_clr;
    logic       idx_adv;
  } key_ctrl_t;

endpackage

// ----- src/rc4sc_keys.sv -----
`timescale 1ns / 1ps

module rc4sc_keys (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rc4sc_pkg::key_ctrl_t ctrl,
  output logic [7:0]           key_byte,
  output logic                 fill_empty
);
  import rc4sc_pkg::*;

  logic [7:0]        key_mem [MAX_KEY_BYTES];
  logic [KEY_CW-1:0] fill_r, fill_nxt;
  logic [KEY_CW-1:0] len_r, len_nxt;
  logic [KEY_AW-1:0] idx_r, idx_nxt;
  logic [KEY_CW-1:0] fill_after;
  logic              room;
  logic [7:0]        key_byte_r;

  assign room       = (fill_r < KEY_CW'(MAX_KEY_BYTES));
  assign fill_after = room ? (fill_r + KEY_CW'(1)) : fill_r;
  assign fill_empty = (fill_r == '0);
  assign key_byte   = key_byte_r;

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    if (ctrl.wr) begin
      if (ctrl.last) begin
        len_nxt  = fill_after;
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_after;
      end
    end
    if (ctrl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctrl.idx_adv) begin
      if ((KEY_CW'(idx_r) + KEY_CW'(1)) == len_r) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = KEY_AW'(KEY_CW'(idx_r) + KEY_CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      idx_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && room) begin
      key_mem[fill_r[KEY_AW-1:0]] <= ctrl.data;
    end
    key_byte_r <= key_mem[idx_r];
  end

endmodule

// ----- src/rc4_stream_cipher.sv -----
// Channel  Handshake             Word
// in       in_valid / in_stall   in_func, in_value, in_last
// out      out_valid / out_stall out_byte_out, out_last_out, out_no_key
//
// A key byte is written to the key store while it has room; a data byte without a loaded key goes through ST_NOKEY.
// A data byte with a key runs these steps: read S[i], read S[j], swap and read S[S[i]+S[j]].
// The last key byte or the last data byte of a keyed message starts a rebuild of the permutation
// (256 fill writes, then 256 steps through ST_KS_RD to ST_KS_W2 on the single permutation memory).
// Reset is synchronous and active low; both memories hold no reset contents.
// A full output register holds the engine in its final step until the word is taken.
`timescale 1ns / 1ps

module rc4_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_value,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_last_out,
  output logic       out_no_key
);
  import rc4sc_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_INIT  = 11'b00000000010,
    ST_KS_RD = 11'b00000000100,
    ST_KS_J  = 11'b00000001000,
    ST_KS_W1 = 11'b00000010000,
    ST_KS_W2 = 11'b00000100000,
    ST_D_J   = 11'b00001000000,
    ST_D_SW  = 11'b00010000000,
    ST_D_OUT = 11'b00100000000,
    ST_NOKEY = 11'b01000000000,
    ST_SPARE = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [7:0] sa_r, sa_nxt;
  logic [7:0] sb_r, sb_nxt;
  logic [7:0] t_r, t_nxt;
  logic [7:0] val_r, val_nxt;
  logic       last_r, last_nxt;
  logic       key_valid_r, key_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_no_key_r, out_no_key_nxt;

  logic [7:0] perm_mem [PERM_SIZE];
  logic [7:0] prd_r;
  logic       pw_en;
  logic [7:0] pw_addr;
  logic [7:0] pw_data;
  logic [7:0] pr_addr;

  key_ctrl_t  key_ctrl;
  logic [7:0] key_byte;
  logic       key_fill_empty;

  logic [7:0] j_key_sum;
  logic [7:0] j_dat_sum;
  logic [7:0] t_sum;
  logic [7:0] ks;
  logic       out_free;

  rc4sc_keys u_keys (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (key_ctrl),
    .key_byte   (key_byte),
    .fill_empty (key_fill_empty)
  );

  assign j_key_sum = j_r + prd_r + key_byte;
  assign j_dat_sum = j_r + prd_r;
  assign t_sum     = sa_r + prd_r;
  assign ks        = (t_r == i_r) ? sb_r : ((t_r == j_r) ? sa_r : prd_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_byte_out = out_byte_r;
  assign out_last_out = out_last_r;
  assign out_no_key   = out_no_key_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    t_nxt          = t_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    key_valid_nxt  = key_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_no_key_nxt = out_no_key_r;
    pw_en          = 1'b0;
    pw_addr        = cnt_r;
    pw_data        = cnt_r;
    pr_addr        = cnt_r;
    key_ctrl       = '0;
    key_ctrl.data  = in_value;
    key_ctrl.last  = in_last;
    case (state_r)
      ST_IDLE: begin
        pr_addr = i_r + 8'd1;
        if (in_valid) begin
          val_nxt  = in_value;
          last_nxt = in_last;
          if (in_func == FUNC_KEY) begin
            key_ctrl.wr   = 1'b1;
            key_valid_nxt = in_last || (key_valid_r && !key_fill_empty);
            if (in_last) begin
              state_nxt = ST_INIT;
            end
          end else if (key_valid_r) begin
            i_nxt     = i_r + 8'd1;
            state_nxt = ST_D_J;
          end else begin
            state_nxt = ST_NOKEY;
          end
        end
      end
      ST_INIT: begin
        pw_en            = 1'b1;
        key_ctrl.idx_clr = 1'b1;
        j_nxt            = '0;
        cnt_nxt          = cnt_r + 8'd1;
        if (cnt_r == 8'(PERM_SIZE - 1)) begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        state_nxt = ST_KS_J;
      end
      ST_KS_J: begin
        j_nxt     = j_key_sum;
        pr_addr   = j_key_sum;
        sa_nxt    = prd_r;
        state_nxt = ST_KS_W1;
      end
      ST_KS_W1: begin
        pw_en     = 1'b1;
        pw_addr   = j_r;
        pw_data   = sa_r;
        sb_nxt    = prd_r;
        state_nxt = ST_KS_W2;
      end
      ST_KS_W2: begin
        pw_en            = 1'b1;
        pw_data          = sb_r;
        key_ctrl.idx_adv = 1'b1;
        cnt_nxt          = cnt_r + 8'd1;
        if (cnt_r == 8'(PERM_SIZE - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_D_J: begin
        j_nxt     = j_dat_sum;
        pr_addr   = j_dat_sum;
        sa_nxt    = prd_r;
        state_nxt = ST_D_SW;
      end
      ST_D_SW: begin
        pw_en     = 1'b1;
        pw_addr   = j_r;
        pw_data   = sa_r;
        sb_nxt    = prd_r;
        t_nxt     = t_sum;
        pr_addr   = t_sum;
        state_nxt = ST_D_OUT;
      end
      ST_D_OUT: begin
        pr_addr = t_r;
        if (out_free) begin
          pw_en          = 1'b1;
          pw_addr        = i_r;
          pw_data        = sb_r;
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = val_r ^ ks;
          out_last_nxt   = last_r;
          out_no_key_nxt = 1'b0;
          state_nxt      = last_r ? ST_INIT : ST_IDLE;
        end
      end
      ST_NOKEY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = val_r;
          out_last_nxt   = last_r;
          out_no_key_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      key_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_valid_r <= key_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sa_r         <= sa_nxt;
    sb_r         <= sb_nxt;
    t_r          <= t_nxt;
    val_r        <= val_nxt;
    last_r       <= last_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_no_key_r <= out_no_key_nxt;
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      perm_mem[pw_addr] <= pw_data;
    end
    prd_r <= perm_mem[pr_addr];
  end

endmodule

// ----- bench/rc4_stream_cipher_tb.sv -----
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4sc_pkg::*;

  localparam int RANDOM_WORDS = 1900;
  localparam int IDLE_LIMIT   = 8000;
  localparam int DRAIN_CYCLES = 1400;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic       func;
    logic [7:0] value;
    logic       last;
  } cipher_in_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       no_key;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_func = 1'b0;
  logic [7:0] in_value = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_out;
  logic       out_last_out;
  logic       out_no_key;

  rc4_stream_cipher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_out (out_byte_out),
    .out_last_out (out_last_out),
    .out_no_key   (out_no_key)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cipher_in_t  pending_words[$];
  cipher_out_t cipher_q[$];

  logic [7:0] perm_s [PERM_SIZE];
  logic [7:0] key_bytes_mem [MAX_KEY_BYTES];
  int         sched_len = 0;
  int         key_count = 0;
  logic [7:0] ks_i = 8'h00;
  logic [7:0] ks_j = 8'h00;
  logic       have_key = 1'b0;

  int errors = 0;
  int results_seen = 0;
  int key_words = 0;
  int data_words = 0;
  int plain_passes = 0;
  int keys_loaded = 0;
  int longest_key = 0;
  int messages_done = 0;
  int cyc = 0;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic int pick_gap();
    int r;
    if (((cyc >> 8) & 3) == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic schedule_key();
    logic [7:0] j;
    logic [7:0] t;
    j = 8'h00;
    for (int n = 0; n < PERM_SIZE; n++) perm_s[n] = n[7:0];
    for (int n = 0; n < PERM_SIZE; n++) begin
      j = j + perm_s[n] + key_bytes_mem[n % sched_len];
      t = perm_s[n];
      perm_s[n] = perm_s[j];
      perm_s[j] = t;
    end
    ks_i = 8'h00;
    ks_j = 8'h00;
  endtask

  task automatic cipher_word(input logic func, input logic [7:0] value, input logic last);
    logic [7:0] t;
    logic [7:0] ks;
    if (func == FUNC_KEY) begin
      key_words++;
      if (key_count == 0) have_key = 1'b0;
      if (key_count < MAX_KEY_BYTES) begin
        key_bytes_mem[key_count] = value;
        key_count++;
      end
      if (last) begin
        sched_len = key_count;
        key_count = 0;
        if (sched_len > 0) begin
          have_key = 1'b1;
          keys_loaded++;
          if (sched_len > longest_key) longest_key = sched_len;
          schedule_key();
        end
      end
    end else if (!have_key) begin
      data_words++;
      plain_passes++;
      cipher_q.push_back('{data: value, last: last, no_key: 1'b1});
    end else begin
      data_words++;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + perm_s[ks_i];
      t = perm_s[ks_i];
      perm_s[ks_i] = perm_s[ks_j];
      perm_s[ks_j] = t;
      ks = perm_s[perm_s[ks_i] + perm_s[ks_j]];
      cipher_q.push_back('{data: value ^ ks, last: last, no_key: 1'b0});
      if (last) begin
        messages_done++;
        schedule_key();
      end
    end
  endtask

  task automatic push_word(input logic func, input logic [7:0] value, input logic last);
    pending_words.push_back('{func: func, value: value, last: last});
  endtask

  task automatic push_key(input int len);
    for (int k = 0; k < len; k++) push_word(FUNC_KEY, 8'($urandom), k == len - 1);
  endtask

  task automatic push_message(input int len);
    for (int k = 0; k < len; k++) push_word(FUNC_DATA, 8'($urandom), k == len - 1);
  endtask

  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cipher_word(in_func, in_value, in_last);
        pending_words.delete(0);
        gap_left = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_func  <= pending_words[0].func;
          in_value <= pending_words[0].value;
          in_last  <= pending_words[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int   stall_left = 0;
  int   hold_left = 0;
  logic pressure_done = 1'b0;
  cipher_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (cipher_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word byte=%02h last=%0b no_key=%0b", $time,
                   out_byte_out, out_last_out, out_no_key);
        end else begin
          want = cipher_q[0];
          cipher_q.delete(0);
          if (out_byte_out !== want.data) begin
            errors++;
            $display("%0t: byte_out expected %02h actual %02h", $time, want.data, out_byte_out);
          end
          if (out_last_out !== want.last) begin
            errors++;
            $display("%0t: last_out expected %0b actual %0b", $time, want.last, out_last_out);
          end
          if (out_no_key !== want.no_key) begin
            errors++;
            $display("%0t: no_key expected %0b actual %0b", $time, want.no_key, out_no_key);
          end
        end
      end
      if (!pressure_done && results_seen >= 200) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("[rc4_stream_cipher] ERROR");
        $finish;
      end
    end
  end

  int pick;
  int scen;
  int start_size;

  initial begin
    // Data before any key passes through unchanged.
    push_word(FUNC_DATA, 8'h00, 1'b0);
    push_word(FUNC_DATA, 8'hFF, 1'b1);
    push_word(FUNC_KEY, 8'hFF, 1'b1);
    push_word(FUNC_DATA, 8'h00, 1'b0);
    push_word(FUNC_DATA, 8'hFF, 1'b0);
    push_word(FUNC_DATA, 8'hA5, 1'b1);
    push_word(FUNC_KEY, 8'h00, 1'b0);
    push_word(FUNC_KEY, 8'h01, 1'b0);
    push_word(FUNC_KEY, 8'h80, 1'b0);
    push_word(FUNC_KEY, 8'h7F, 1'b0);
    push_word(FUNC_KEY, 8'hFF, 1'b1);
    push_word(FUNC_DATA, 8'h55, 1'b0);
    push_word(FUNC_DATA, 8'hAA, 1'b0);
    // A new key drops the old one until its last byte arrives.
    push_word(FUNC_KEY, 8'h3C, 1'b0);
    push_word(FUNC_DATA, 8'h12, 1'b0);
    push_word(FUNC_DATA, 8'h34, 1'b1);
    push_word(FUNC_KEY, 8'h99, 1'b1);
    push_word(FUNC_DATA, 8'hFF, 1'b1);

    start_size = pending_words.size();
    scen = 0;
    while (pending_words.size() < start_size + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (scen == 2 || scen == 6 || pick < 70) begin
        if (scen == 2) push_key(270);
        else if (scen == 6) push_key(MAX_KEY_BYTES);
        else if (pick < 6) push_key($urandom_range(17, 255));
        else push_key($urandom_range(1, 16));
        repeat ($urandom_range(1, 4)) push_message($urandom_range(1, 40));
      end else if (pick < 80) begin
        push_message($urandom_range(1, 40));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) push_word(FUNC_KEY, 8'($urandom), 1'b0);
        push_message($urandom_range(1, 3));
        push_key($urandom_range(1, 8));
        push_message($urandom_range(1, 20));
      end else begin
        repeat ($urandom_range(1, 8)) push_word(1'($urandom), 8'($urandom), 1'($urandom));
      end
      scen++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0) @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key bytes and %0d data bytes; %0d keys loaded, longest %0d bytes.",
             key_words, data_words, keys_loaded, longest_key);
    $display("Checked %0d results: %0d keyed messages closed, %0d bytes passed without key.",
             results_seen, messages_done, plain_passes);
    if (errors == 0) begin
      $display("[rc4_stream_cipher] OK");
    end else begin
      $display("[rc4_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
